/* hdl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp and first_fit_heap_allocator_top; no dependencies.
`default_nettype none

package ffha_pkg;

   // default sizing
   localparam int MAX_BLOCKS_DEF  = 64;
   localparam int OFFSET_BITS_DEF = 24;

   // request opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_INVALID    = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_ARENA_LENGTH = 2'd0;
   localparam logic [1:0] CSR_BLOCK_HDR    = 2'd1;
   localparam logic [1:0] CSR_ZONE_HDR     = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] request_bytes;
      logic [23:0] data_offset_in;
   } req_type;

   typedef struct packed {
      logic [23:0] data_offset;
      logic [1:0]  status;
      logic [23:0] bytes_in_use;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       init;
      logic       accept;
      logic       rd_start;
      logic       step;
      logic       capture;
      logic       split;
      logic       alloc_wb;
      logic       free_wb;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_op;
      logic       pre_fail;
      logic       is_alloc;
      logic       hit;
      logic       hit_used;
      logic       walk_end;
      logic       need_split;
      logic       slot_full;
      logic       rsp_free;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/ffha_ctrl.sv */
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg; drives ffha_dp through cmd_type and reads stat_type.
`default_nettype none

module ffha_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffha_pkg::stat_type st,
   output ffha_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_BOOT,
      S_IDLE,
      S_WALK,
      S_SPLIT,
      S_ALLOC_WB,
      S_FREE_NX,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  status_ff, status_in;
   logic        stall_ff, stall_in;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      case (state_ff)
         S_BOOT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept   = 1'b1;
               cmd.rd_start = 1'b1;
               case (st.req_op)
                  ffha_pkg::OP_ALLOC: begin
                     if (st.pre_fail) begin
                        status_in = ffha_pkg::ST_NO_SPACE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  ffha_pkg::OP_FREE: begin
                     state_in = S_WALK;
                  end
                  ffha_pkg::OP_INIT: begin
                     cmd.init  = 1'b1;
                     status_in = ffha_pkg::ST_OK;
                     state_in  = S_DONE;
                  end
                  default: begin
                     status_in = ffha_pkg::ST_INVALID;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (st.hit) begin
               cmd.capture = 1'b1;
               if (st.is_alloc) begin
                  if (st.need_split) begin
                     if (st.slot_full) begin
                        status_in = ffha_pkg::ST_TABLE_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SPLIT;
                     end
                  end else begin
                     state_in = S_ALLOC_WB;
                  end
               end else if (st.hit_used) begin
                  // read of the following block is under way
                  state_in = S_FREE_NX;
               end else begin
                  status_in = ffha_pkg::ST_INVALID;
                  state_in  = S_DONE;
               end
            end else begin
               cmd.step = 1'b1;
               if (st.walk_end) begin
                  status_in = st.is_alloc ? ffha_pkg::ST_NO_SPACE : ffha_pkg::ST_INVALID;
                  state_in  = S_DONE;
               end
            end
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_ALLOC_WB;
         end
         S_ALLOC_WB: begin
            cmd.alloc_wb = 1'b1;
            status_in    = ffha_pkg::ST_OK;
            state_in     = S_DONE;
         end
         S_FREE_NX: begin
            cmd.free_wb = 1'b1;
            status_in   = ffha_pkg::ST_OK;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.rsp_status = status_ff;
      stall_in       = (state_in != S_IDLE);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_BOOT;
         status_ff <= ffha_pkg::ST_OK;
         stall_ff  <= 1'b1;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         stall_ff  <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

/* hdl/ffha_dp.sv */
// Datapath of the first-fit heap allocator: block table, free-slot stack,
// configuration registers and result register. Depends on ffha_pkg.
`default_nettype none

module ffha_dp #(
   parameter int MAX_BLOCKS  = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int OFFSET_BITS = ffha_pkg::OFFSET_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffha_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffha_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_data,
   input  wire ffha_pkg::cmd_type cmd,
   output ffha_pkg::stat_type     st
);

   localparam int IDXW  = $clog2(MAX_BLOCKS);
   localparam int LINKW = $clog2(MAX_BLOCKS + 1);
   localparam int CW    = (OFFSET_BITS > 24 ? OFFSET_BITS : 24) + 2;
   localparam logic [LINKW-1:0] LINK_NULL = LINKW'(MAX_BLOCKS);
   localparam logic [IDXW-1:0]  STEP_LAST = IDXW'(MAX_BLOCKS - 1);
   localparam logic [CW-1:0]    OFS_MASK  = {{(CW-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset;
      logic [OFFSET_BITS-1:0] length;
      logic                   used;
      logic [LINKW-1:0]       next;
   } entry_type;

   // configuration
   logic [23:0] arena_ff;
   logic [6:0]  hdr_ff;
   logic [6:0]  zone_ff;

   // latched request and walk state
   logic [1:0]       op_ff;
   logic [23:0]      req_ff;
   logic [23:0]      dofs_ff;
   logic [IDXW-1:0]  cur_ff;
   logic [IDXW-1:0]  step_ff;
   entry_type        found_ff;
   logic [IDXW-1:0]  found_idx_ff;
   logic             split_ff;
   logic [IDXW-1:0]  slot_ff;

   // block table and free-slot stack
   entry_type        entry_mem [MAX_BLOCKS];
   entry_type        rd_data_ff;
   logic [IDXW-1:0]  rd_addr;
   logic             wr_en;
   logic [IDXW-1:0]  wr_addr;
   entry_type        wr_data;
   logic [IDXW-1:0]  stack_mem [MAX_BLOCKS];
   logic [IDXW-1:0]  top_ff;
   logic [LINKW-1:0] sp_ff;
   logic [LINKW-1:0] fresh_ff;

   // totals and result
   logic [OFFSET_BITS-1:0] total_ff;
   logic [23:0]            data_ff;
   logic                   rsp_valid_ff;
   ffha_pkg::rsp_type      rsp_ff;

   // widened working values
   logic [CW-1:0] hdr_w, hdr2_w, req_w, total_w, arena_w, in_req_w;
   logic [CW-1:0] rd_len_w, rd_remain_w, rd_data_ofs_w, dofs_w;
   logic [CW-1:0] f_ofs_w, f_len_w, f_remain_w, new_ofs_w, new_len_w, f_data_w;
   logic [CW-1:0] init_over_w, init_len_w, merge_w, merge_sat_w, total_add_w, total_sub_w;
   logic [IDXW-1:0] new_slot;
   logic [IDXW-1:0] sp_m1;
   logic            merge;

   assign hdr_w    = CW'(hdr_ff);
   assign hdr2_w   = CW'({hdr_ff, 1'b0});
   assign req_w    = CW'(req_ff);
   assign in_req_w = CW'(req_payload.request_bytes);
   assign total_w  = CW'(total_ff);
   assign arena_w  = CW'(arena_ff);
   assign dofs_w   = CW'(dofs_ff);

   // entry under the walk
   assign rd_len_w      = CW'(rd_data_ff.length);
   assign rd_remain_w   = rd_len_w - req_w;
   assign rd_data_ofs_w = (CW'(rd_data_ff.offset) + hdr_w) & OFS_MASK;

   // captured entry
   assign f_ofs_w    = CW'(found_ff.offset);
   assign f_len_w    = CW'(found_ff.length);
   assign f_remain_w = f_len_w - req_w;
   assign new_ofs_w  = f_ofs_w + hdr_w + req_w;
   assign new_len_w  = f_remain_w - hdr2_w;
   assign f_data_w   = (f_ofs_w + hdr_w) & OFS_MASK;

   // arena rebuild
   assign init_over_w = CW'(zone_ff) + hdr_w;
   assign init_len_w  = (arena_w > init_over_w) ? (arena_w - init_over_w) : '0;

   // merge with the following block
   assign merge       = (found_ff.next < LINK_NULL) && !rd_data_ff.used;
   assign merge_w     = f_len_w + CW'(rd_data_ff.length) + hdr_w;
   assign merge_sat_w = (merge_w > OFS_MASK) ? OFS_MASK : merge_w;

   assign total_add_w = total_w + req_w;
   assign total_sub_w = (total_w >= f_len_w) ? (total_w - f_len_w) : '0;

   assign sp_m1    = IDXW'(sp_ff - LINKW'(1));
   assign new_slot = (sp_ff != '0) ? top_ff : fresh_ff[IDXW-1:0];

   // status toward the controller
   always_comb begin
      st.req_op     = req_payload.op;
      st.pre_fail   = (in_req_w == '0) || (total_w >= arena_w)
                      || (in_req_w >= (arena_w - total_w));
      st.is_alloc   = (op_ff == ffha_pkg::OP_ALLOC);
      st.hit        = st.is_alloc ? (!rd_data_ff.used && (rd_len_w >= req_w))
                                  : (rd_data_ofs_w == dofs_w);
      st.hit_used   = rd_data_ff.used;
      st.walk_end   = (step_ff == STEP_LAST) || (rd_data_ff.next >= LINK_NULL);
      st.need_split = rd_remain_w > hdr2_w;
      st.slot_full  = (sp_ff == '0) && (fresh_ff == LINK_NULL);
      st.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // table read address: slot 0 to start a walk, else the link just read
   assign rd_addr = cmd.rd_start ? '0 : rd_data_ff.next[IDXW-1:0];

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = found_idx_ff;
      wr_data = found_ff;
      if (cmd.init) begin
         wr_en          = 1'b1;
         wr_addr        = '0;
         wr_data.offset = OFFSET_BITS'(zone_ff);
         wr_data.length = init_len_w[OFFSET_BITS-1:0];
         wr_data.used   = 1'b0;
         wr_data.next   = LINK_NULL;
      end else if (cmd.split) begin
         wr_en          = 1'b1;
         wr_addr        = new_slot;
         wr_data.offset = new_ofs_w[OFFSET_BITS-1:0];
         wr_data.length = new_len_w[OFFSET_BITS-1:0];
         wr_data.used   = 1'b0;
         wr_data.next   = found_ff.next;
      end else if (cmd.alloc_wb) begin
         wr_en          = 1'b1;
         wr_data.length = req_w[OFFSET_BITS-1:0];
         wr_data.used   = 1'b1;
         wr_data.next   = split_ff ? LINKW'(slot_ff) : found_ff.next;
      end else if (cmd.free_wb) begin
         wr_en        = 1'b1;
         wr_data.used = 1'b0;
         if (merge) begin
            wr_data.length = merge_sat_w[OFFSET_BITS-1:0];
            wr_data.next   = rd_data_ff.next;
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
      if (cmd.free_wb && merge) begin
         stack_mem[sp_ff[IDXW-1:0]] <= found_ff.next[IDXW-1:0];
      end
      top_ff <= stack_mem[sp_m1];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff     <= 24'd1048576;
         hdr_ff       <= 7'd16;
         zone_ff      <= 7'd24;
         sp_ff        <= '0;
         fresh_ff     <= LINKW'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ffha_pkg::CSR_ARENA_LENGTH: arena_ff <= csr_data;
               ffha_pkg::CSR_BLOCK_HDR:    hdr_ff   <= csr_data[6:0];
               ffha_pkg::CSR_ZONE_HDR:     zone_ff  <= csr_data[6:0];
               default: ;
            endcase
         end
         if (cmd.init) begin
            sp_ff    <= '0;
            fresh_ff <= LINKW'(1);
            total_ff <= '0;
         end else if (cmd.split) begin
            if (sp_ff != '0) begin
               sp_ff <= sp_ff - LINKW'(1);
            end else begin
               fresh_ff <= fresh_ff + LINKW'(1);
            end
         end else if (cmd.alloc_wb) begin
            total_ff <= total_add_w[OFFSET_BITS-1:0];
         end else if (cmd.free_wb) begin
            total_ff <= total_sub_w[OFFSET_BITS-1:0];
            if (merge) begin
               sp_ff <= sp_ff + LINKW'(1);
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_payload.op;
         req_ff   <= req_payload.request_bytes;
         dofs_ff  <= req_payload.data_offset_in;
         cur_ff   <= '0;
         step_ff  <= '0;
         split_ff <= 1'b0;
         data_ff  <= '0;
      end else if (cmd.step) begin
         cur_ff  <= rd_data_ff.next[IDXW-1:0];
         step_ff <= step_ff + IDXW'(1);
      end
      if (cmd.capture) begin
         found_ff     <= rd_data_ff;
         found_idx_ff <= cur_ff;
      end
      if (cmd.split) begin
         split_ff <= 1'b1;
         slot_ff  <= new_slot;
      end
      if (cmd.alloc_wb) begin
         data_ff <= f_data_w[23:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.data_offset  <= data_ff;
         rsp_ff.status       <= cmd.rsp_status;
         rsp_ff.bytes_in_use <= total_w[23:0];
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* hdl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator for one arena: a block table walked in address
// order, one table entry per cycle through the single read port of the table.
// An item refused up front, a reinitialise or an unknown op goes from accept
// to the result load; an allocate or free runs accept, the walk, its writebacks
// (split, allocation or free) and the result load. One item is in work at a
// time, and the next is taken while the previous result waits in the output
// register. After reset the block stalls while it writes the initial free
// block. Register writes never rebuild the table by themselves: the arena
// layout changes at the next reinitialise request or reset.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
`default_nettype none

module first_fit_heap_allocator_top #(
   parameter int MAX_BLOCKS  = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int OFFSET_BITS = ffha_pkg::OFFSET_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffha_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffha_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_data
);

   ffha_pkg::cmd_type  cmd;
   ffha_pkg::stat_type st;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ffha_dp #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .st          (st)
   );

endmodule

`default_nettype wire

/* verif/first_fit_heap_allocator_top_tb.sv */
// Self-checking bench for the first-fit heap allocator: drives allocate, free,
// reinitialise and unknown items plus register writes, and checks each result.
// Depends on ffha_pkg and first_fit_heap_allocator_top.

// Predicts the allocator and checks its results in order
class heap_scoreboard;
   localparam int SLOTS = 64;
   localparam logic [23:0] OFS_MAX = 24'hFFFFFF;

   // register copies
   logic [23:0] arena_len  = 24'd1048576;
   logic [6:0]  hdr_bytes  = 7'd16;
   logic [6:0]  zone_bytes = 7'd24;

   // block table copy
   logic [23:0] blk_ofs [SLOTS];
   logic [23:0] blk_len [SLOTS];
   bit          blk_used[SLOTS];
   int          blk_next[SLOTS];
   bit          slot_busy[SLOTS];
   logic [23:0] in_use;

   ffha_pkg::rsp_type rsp_wait_q[$];
   logic [23:0]       live_q[$];
   int                fails = 0;

   function new();
      rebuild();
   endfunction

   function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
         ffha_pkg::CSR_ARENA_LENGTH: arena_len = val;
         ffha_pkg::CSR_BLOCK_HDR:    hdr_bytes = val[6:0];
         ffha_pkg::CSR_ZONE_HDR:     zone_bytes = val[6:0];
         default: ;
      endcase
   endfunction

   function void rebuild();
      int overhead;
      overhead = int'(zone_bytes) + int'(hdr_bytes);
      for (int i = 0; i < SLOTS; i++) begin
         blk_ofs[i] = '0; blk_len[i] = '0; blk_used[i] = 0;
         blk_next[i] = SLOTS; slot_busy[i] = 0;
      end
      slot_busy[0] = 1;
      blk_ofs[0] = 24'(zone_bytes);
      blk_len[0] = (int'(arena_len) > overhead) ? 24'(int'(arena_len) - overhead) : '0;
      in_use = '0;
      live_q.delete();
   endfunction

   function logic [1:0] do_alloc(logic [23:0] req, output logic [23:0] data);
      int idx, found, ns;
      logic [23:0] remain;
      idx = 0; found = -1; ns = -1;
      data = '0;
      if (req == 0 || in_use >= arena_len) return ffha_pkg::ST_NO_SPACE;
      if (req >= arena_len - in_use) return ffha_pkg::ST_NO_SPACE;
      for (int s = 0; s < SLOTS && idx < SLOTS; s++) begin
         if (!blk_used[idx] && blk_len[idx] >= req) begin
            found = idx;
            break;
         end
         idx = blk_next[idx];
      end
      if (found < 0) return ffha_pkg::ST_NO_SPACE;
      remain = blk_len[found] - req;
      if (int'(remain) > 2 * int'(hdr_bytes)) begin
         for (int i = 0; i < SLOTS; i++)
            if (!slot_busy[i]) begin
               ns = i;
               break;
            end
         if (ns < 0) return ffha_pkg::ST_TABLE_FULL;
         slot_busy[ns] = 1;
         blk_ofs[ns]  = 24'(int'(blk_ofs[found]) + int'(hdr_bytes) + int'(req));
         blk_len[ns]  = 24'(int'(remain) - 2 * int'(hdr_bytes));
         blk_used[ns] = 0;
         blk_next[ns] = blk_next[found];
         blk_next[found] = ns;
      end
      blk_len[found]  = req;
      blk_used[found] = 1;
      in_use = in_use + req;
      data = 24'(int'(blk_ofs[found]) + int'(hdr_bytes));
      return ffha_pkg::ST_OK;
   endfunction

   function logic [1:0] do_free(logic [23:0] dofs);
      int idx, found, nx;
      longint total;
      idx = 0; found = -1;
      for (int s = 0; s < SLOTS && idx < SLOTS; s++) begin
         if (24'(int'(blk_ofs[idx]) + int'(hdr_bytes)) == dofs) begin
            found = idx;
            break;
         end
         idx = blk_next[idx];
      end
      if (found < 0 || !blk_used[found]) return ffha_pkg::ST_INVALID;
      blk_used[found] = 0;
      in_use = (in_use >= blk_len[found]) ? in_use - blk_len[found] : '0;
      nx = blk_next[found];
      if (nx < SLOTS && !blk_used[nx]) begin
         total = longint'(blk_len[found]) + longint'(blk_len[nx]) + longint'(hdr_bytes);
         blk_len[found] = (total > longint'(OFS_MAX)) ? OFS_MAX : 24'(total);
         blk_next[found] = blk_next[nx];
         slot_busy[nx] = 0; blk_ofs[nx] = '0; blk_len[nx] = '0;
         blk_used[nx] = 0; blk_next[nx] = SLOTS;
      end
      foreach (live_q[i])
         if (live_q[i] == dofs) begin
            live_q.delete(i);
            break;
         end
      return ffha_pkg::ST_OK;
   endfunction

   // an item was accepted: work out its result
   function void note_item(ffha_pkg::req_type r);
      ffha_pkg::rsp_type e;
      logic [23:0] data;
      data = '0;
      case (r.op)
         ffha_pkg::OP_ALLOC: begin
            e.status = do_alloc(r.request_bytes, data);
            if (e.status == ffha_pkg::ST_OK) live_q.push_back(data);
         end
         ffha_pkg::OP_FREE: e.status = do_free(r.data_offset_in);
         ffha_pkg::OP_INIT: begin
            rebuild();
            e.status = ffha_pkg::ST_OK;
         end
         default: e.status = ffha_pkg::ST_INVALID;
      endcase
      e.data_offset  = data;
      e.bytes_in_use = in_use;
      rsp_wait_q.push_back(e);
   endfunction

   function void check_result(ffha_pkg::rsp_type got);
      ffha_pkg::rsp_type e;
      if (rsp_wait_q.size() == 0) begin
         fails++;
         if (fails <= 10) $display("unexpected result %h", got);
         return;
      end
      e = rsp_wait_q.pop_front();
      if (got.data_offset !== e.data_offset || got.status !== e.status ||
          got.bytes_in_use !== e.bytes_in_use) begin
         fails++;
         if (fails <= 10)
            $display("mismatch: exp ofs %h st %0d use %h, got ofs %h st %0d use %h",
                     e.data_offset, e.status, e.bytes_in_use,
                     got.data_offset, got.status, got.bytes_in_use);
      end
   endfunction

   function int pending();
      return rsp_wait_q.size();
   endfunction
endclass

module first_fit_heap_allocator_top_tb;

   // opcode with no meaning to the block
   localparam logic [1:0] OP_UNDEF = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ffha_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   ffha_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [23:0]       csr_data;

   heap_scoreboard sb;
   bit squeeze_req;

   first_fit_heap_allocator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   // mostly short gaps, a few long ones
   function int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   // send one item; valid stays high when the next item follows at once
   task send_item(input ffha_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
   endtask

   task send_op(input logic [1:0] op, input logic [23:0] bytes, input logic [23:0] ofs);
      ffha_pkg::req_type r;
      r.op = op; r.request_bytes = bytes; r.data_offset_in = ofs;
      send_item(r);
   endtask

   // drain all results before touching registers
   task wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task write_reg(input logic [1:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // new settings, then a reinitialise so they take hold
   task set_arena(input logic [23:0] alen, input logic [23:0] hdr, input logic [23:0] zone);
      wait_idle();
      write_reg(ffha_pkg::CSR_ARENA_LENGTH, alen);
      write_reg(ffha_pkg::CSR_BLOCK_HDR, hdr);
      write_reg(ffha_pkg::CSR_ZONE_HDR, zone);
      send_op(ffha_pkg::OP_INIT, 24'($urandom()), 24'($urandom()));
   endtask

   task random_item(input int free_pct);
      int k;
      logic [23:0] bytes, ofs;
      k = $urandom_range(0, 99);
      bytes = 24'($urandom());
      ofs = 24'($urandom());
      if (k < free_pct) begin
         if (sb.live_q.size() > 0 && $urandom_range(0, 9) < 8)
            ofs = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
         send_op(ffha_pkg::OP_FREE, bytes, ofs);
      end else if (k < 96) begin
         case ($urandom_range(0, 9))
            0:       bytes = 24'($urandom());
            1:       bytes = 24'($urandom_range(0, int'(sb.arena_len) + 2));
            2:       bytes = '0;
            default: bytes = 24'($urandom_range(1, 64));
         endcase
         send_op(ffha_pkg::OP_ALLOC, bytes, ofs);
      end else if (k < 98)
         send_op(ffha_pkg::OP_INIT, bytes, ofs);
      else
         send_op(OP_UNDEF, bytes, ofs);
   endtask

   task random_phase(input int n, input int free_pct);
      repeat (n) random_item(free_pct);
   endtask

   // receiver: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      int k;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_payload);
         if (squeeze_req) begin
            squeeze_req = 0;
            stall_left = 400;
         end else if (stall_left == 0) begin
            k = $urandom_range(0, 99);
            if (k < 8) stall_left = $urandom_range(1, 4);
            else if (k < 10) stall_left = $urandom_range(20, 60);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else
            rsp_stall <= 1'b0;
      end
   end

   initial begin
      sb = new();
      squeeze_req = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: default arena
      send_op(ffha_pkg::OP_ALLOC, 24'd0, 24'hFFFFFF);        // zero size
      send_op(ffha_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);        // oversized
      send_op(ffha_pkg::OP_ALLOC, 24'd1048540, 24'd0);       // no block fits
      send_op(ffha_pkg::OP_ALLOC, 24'd100, 24'd0);
      send_op(ffha_pkg::OP_ALLOC, 24'd1, 24'd0);
      send_op(ffha_pkg::OP_FREE, 24'd0, sb.live_q[0]);       // free, no merge
      send_op(ffha_pkg::OP_FREE, 24'd0, 24'd40);             // double free
      send_op(ffha_pkg::OP_FREE, 24'd0, 24'd0);              // no such block
      send_op(ffha_pkg::OP_FREE, 24'd0, sb.live_q[0]);       // merge with tail
      send_op(OP_UNDEF, 24'hFFFFFF, 24'hFFFFFF);             // unknown op
      send_op(ffha_pkg::OP_INIT, 24'h5A5A5A, 24'hA5A5A5);
      send_op(ffha_pkg::OP_ALLOC, 24'd1048526, 24'd0);       // leftover dropped
      send_op(ffha_pkg::OP_FREE, 24'd0, sb.live_q[0]);
      send_op(ffha_pkg::OP_ALLOC, 24'd10, 24'd0);
      send_op(ffha_pkg::OP_ALLOC, 24'd20, 24'd0);
      send_op(ffha_pkg::OP_FREE, 24'd0, sb.live_q[1]);
      send_op(ffha_pkg::OP_FREE, 24'd0, sb.live_q[0]);

      // random, with one long receiver hold-off
      random_phase(30, 30);
      squeeze_req = 1;
      random_phase(40, 30);

      set_arena(24'd200, 24'd4, 24'd4);
      random_phase(50, 35);

      set_arena(24'd0, 24'd64, 24'd64);
      random_phase(15, 30);

      // large arena, alloc heavy to run the table out of slots
      set_arena(24'hFFFFFF, 24'd63, 24'd4);
      random_phase(130, 8);

      set_arena(24'd4096, 24'd4, 24'd64);
      random_phase(60, 40);

      set_arena(24'd1048576, 24'd16, 24'd24);
      random_phase(60, 35);

      wait_idle();
      if (sb.fails == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
